### rtl/css_pkg.sv
// Shared types, codes and helper functions of the clock step sequencer.
// No dependencies.
package css_pkg;

	localparam int MAX_STEPS = 16;
	localparam int STEP_W    = 4;
	localparam int COUNT_W   = 5;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_LOAD    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [0:0] REG_STEP_COUNT  = 1'b0;
	localparam logic [0:0] REG_PULSE_TICKS = 1'b1;

	localparam logic [COUNT_W-1:0] STEP_COUNT_RST  = 5'd1;
	localparam logic [15:0]        PULSE_TICKS_RST = 16'd48;
	localparam logic [6:0]         PROB_FULL       = 7'd100;

	typedef struct packed {
		logic [31:0] inc;
		logic [15:0] rep;
		logic        dflag;
		logic [31:0] dur;
		logic [6:0]  prob;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [STEP_W-1:0] idx;
		logic              wrap;
		logic              token;
	} advance_t;

	function automatic logic draw_play(input logic [6:0] prob, input logic [15:0] rnd);
		logic [22:0] lhs;
		logic [22:0] rhs;
		logic        res;
		lhs = 23'(rnd) * 23'(PROB_FULL);
		rhs = {prob, 16'h0000};
		if (prob >= PROB_FULL) begin
			res = 1'b1;
		end else if (prob == 7'd0) begin
			res = 1'b0;
		end else begin
			res = lhs < rhs;
		end
		return res;
	endfunction

	function automatic logic [COUNT_W-1:0] used_steps(input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] res;
		if (cnt == '0) begin
			res = COUNT_W'(1);
		end else if (cnt > COUNT_W'(MAX_STEPS)) begin
			res = COUNT_W'(MAX_STEPS);
		end else begin
			res = cnt;
		end
		return res;
	endfunction

	function automatic advance_t next_index(input logic [STEP_W-1:0] idx,
			input logic [COUNT_W-1:0] steps);
		advance_t res;
		if ({1'b0, idx} + COUNT_W'(1) >= steps) begin
			res.idx   = '0;
			res.wrap  = 1'b1;
			res.token = steps > COUNT_W'(1);
		end else begin
			res.idx   = idx + STEP_W'(1);
			res.wrap  = 1'b0;
			res.token = 1'b1;
		end
		return res;
	endfunction

	function automatic logic [15:0] fire(input logic [15:0] left, input logic [15:0] len);
		return (left < len) ? len : left;
	endfunction

endpackage

### rtl/css_ifs.sv
// Item and result channels of the clock step sequencer, valid/ready transfer.
// Depends on css_pkg.
interface css_item_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                opcode;
	logic [css_pkg::STEP_W-1:0] step_slot;
	logic [31:0]               step_phase_inc;
	logic [15:0]               step_repeat;
	logic                      step_has_duration;
	logic [31:0]               step_duration_ticks;
	logic [6:0]                step_probability;
	logic [15:0]               random_value;

	modport source(output valid, opcode, step_slot, step_phase_inc, step_repeat,
		step_has_duration, step_duration_ticks, step_probability, random_value,
		input ready);
	modport sink(input valid, opcode, step_slot, step_phase_inc, step_repeat,
		step_has_duration, step_duration_ticks, step_probability, random_value,
		output ready);
endinterface

interface css_result_if;
	logic                      valid;
	logic                      ready;
	logic                      clock_gate;
	logic                      token_eoc;
	logic                      cycle_eoc;
	logic [css_pkg::STEP_W-1:0] current_step;
	logic [31:0]               ramp;

	modport source(output valid, clock_gate, token_eoc, cycle_eoc, current_step, ramp,
		input ready);
	modport sink(input valid, clock_gate, token_eoc, cycle_eoc, current_step, ramp,
		output ready);
endinterface

### rtl/clock_step_sequencer.sv
// Clock step sequencer: step table in css_ram, phase and counters in flops.
// Result is registered. One item per cycle while the result channel is not stalled;
// a tick that enters a new step (at most two steps per tick) passes through ST_B and/or ST_C, and a
// restart through ST_C, before the next item is taken, as the new step's entry comes from the RAM read port.
// arst_n resets control state and the config registers; the step table and the payload registers are not cleared.
// Depends on css_pkg, css_ifs and css_ram.
module clock_step_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [0:0]          wr_index,
	input  logic [15:0]         wr_data,
	css_item_if.sink            items,
	css_result_if.source        results
);

	localparam logic [1:0] ST_A = 2'd0;
	localparam logic [1:0] ST_B = 2'd1;
	localparam logic [1:0] ST_C = 2'd2;

	localparam int SW = css_pkg::STEP_W;

	logic [1:0]                  st_q, st_n;
	logic [31:0]                 phase_q, phase_n;
	logic [SW-1:0]               idx_q, idx_n;
	logic [15:0]                 beat_q, beat_n;
	logic [31:0]                 el_q, el_n;
	logic                        plays_q, plays_n;
	logic                        lowp_q, lowp_n;
	logic                        highp_q, highp_n;
	logic [15:0]                 tokl_q, tokl_n;
	logic [15:0]                 cycl_q, cycl_n;
	logic [15:0]                 rnd_q, rnd_n;
	logic                        tick_q, tick_n;
	logic [css_pkg::COUNT_W-1:0] step_count_q;
	logic [15:0]                 pulse_q;
	logic                        fwd_vld_q, fwd_vld_n;
	css_pkg::entry_t             fwd_q, load_e, e;
	logic [css_pkg::ENTRY_W-1:0] rd_data;
	logic                        ram_we;
	logic [SW-1:0]               raddr;

	logic                        ov_q;
	logic                        gate_q, tok_q, cyc_q;
	logic [SW-1:0]               cur_q;
	logic [31:0]                 ramp_q;

	logic                        out_space, go, fin, fin_tick, do_step;
	logic                        gate, tok, cyc;
	logic [32:0]                 sum;
	logic [15:0]                 rep1;
	css_pkg::advance_t           adv;

	assign out_space = !ov_q || results.ready;
	assign items.ready = (st_q == ST_A) && out_space;

	assign load_e = '{inc: items.step_phase_inc, rep: items.step_repeat,
		dflag: items.step_has_duration, dur: items.step_duration_ticks,
		prob: items.step_probability};
	assign e = fwd_vld_q ? fwd_q : css_pkg::entry_t'(rd_data);

	css_ram #(
		.WIDTH(css_pkg::ENTRY_W),
		.DEPTH(css_pkg::MAX_STEPS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(items.step_slot),
		.wdata(load_e),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_comb begin
		st_n      = st_q;
		phase_n   = phase_q;
		idx_n     = idx_q;
		beat_n    = beat_q;
		el_n      = el_q;
		plays_n   = plays_q;
		lowp_n    = lowp_q;
		highp_n   = highp_q;
		tokl_n    = tokl_q;
		cycl_n    = cycl_q;
		rnd_n     = rnd_q;
		tick_n    = tick_q;
		fwd_vld_n = 1'b0;
		ram_we    = 1'b0;
		fin       = 1'b0;
		fin_tick  = 1'b0;
		do_step   = 1'b0;
		go        = 1'b0;
		gate      = 1'b0;
		tok       = 1'b0;
		cyc       = 1'b0;
		sum       = {1'b0, phase_q} + {1'b0, e.inc};
		rep1      = (e.rep == 16'd0) ? 16'd1 : e.rep;
		adv       = css_pkg::next_index(idx_q, css_pkg::used_steps(step_count_q));

		unique case (st_q)
			ST_A: begin
				go = items.valid && items.ready;
				if (go) begin
					unique case (items.opcode)
						css_pkg::OP_TICK: begin
							phase_n = sum[31:0];
							tick_n  = 1'b1;
							rnd_n   = items.random_value;
							if (sum[32]) begin
								if (e.dflag) begin
									plays_n = css_pkg::draw_play(e.prob, items.random_value);
								end else if ({1'b0, beat_q} + 17'd1 >= {1'b0, rep1}) begin
									do_step = 1'b1;
								end else begin
									beat_n  = beat_q + 16'd1;
									plays_n = css_pkg::draw_play(e.prob, items.random_value);
								end
							end
							if (do_step) begin
								st_n = ST_B;
							end else begin
								if (e.dflag) begin
									el_n = (el_q == 32'hFFFF_FFFF) ? el_q : el_q + 32'd1;
									if (el_n >= e.dur) begin
										do_step = 1'b1;
										st_n    = ST_C;
									end
								end
								if (!do_step) begin
									fin      = 1'b1;
									fin_tick = 1'b1;
								end
							end
						end
						css_pkg::OP_LOAD: begin
							ram_we    = 1'b1;
							fwd_vld_n = items.step_slot == idx_q;
							fin       = 1'b1;
						end
						css_pkg::OP_RESTART: begin
							idx_n   = '0;
							beat_n  = '0;
							el_n    = '0;
							phase_n = '0;
							lowp_n  = 1'b1;
							highp_n = 1'b1;
							plays_n = 1'b1;
							tick_n  = 1'b0;
							rnd_n   = items.random_value;
							st_n    = ST_C;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_B: begin
				plays_n = css_pkg::draw_play(e.prob, rnd_q);
				if (e.dflag) begin
					el_n = (el_q == 32'hFFFF_FFFF) ? el_q : el_q + 32'd1;
					if (el_n >= e.dur) begin
						do_step = 1'b1;
					end
				end
				if (do_step) begin
					st_n = ST_C;
				end else begin
					st_n     = ST_A;
					fin      = 1'b1;
					fin_tick = 1'b1;
				end
				go = !fin || out_space;
			end
			ST_C: begin
				plays_n  = css_pkg::draw_play(e.prob, rnd_q);
				fin      = 1'b1;
				fin_tick = tick_q;
				st_n     = ST_A;
				go       = out_space;
			end
			default: begin
				st_n = ST_A;
				go   = 1'b1;
			end
		endcase

		if (do_step) begin
			idx_n   = adv.idx;
			beat_n  = '0;
			el_n    = '0;
			phase_n = '0;
			lowp_n  = 1'b1;
			highp_n = 1'b1;
			if (adv.wrap) begin
				cycl_n = css_pkg::fire(cycl_n, pulse_q);
			end
			if (adv.token) begin
				tokl_n = css_pkg::fire(tokl_n, pulse_q);
			end
		end

		if (fin_tick) begin
			if (lowp_n) begin
				lowp_n = 1'b0;
				gate   = 1'b0;
			end else begin
				if (highp_n) begin
					highp_n = 1'b0;
					phase_n = '0;
				end
				gate = !phase_n[31];
			end
			gate = gate && plays_n;
			tok  = tokl_n != 16'd0;
			if (tok) begin
				tokl_n = tokl_n - 16'd1;
			end
			cyc = cycl_n != 16'd0;
			if (cyc) begin
				cycl_n = cycl_n - 16'd1;
			end
		end

		raddr = go ? idx_n : idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_A;
			phase_q      <= '0;
			idx_q        <= '0;
			beat_q       <= '0;
			el_q         <= '0;
			plays_q      <= 1'b1;
			lowp_q       <= 1'b0;
			highp_q      <= 1'b0;
			tokl_q       <= '0;
			cycl_q       <= '0;
			tick_q       <= 1'b0;
			fwd_vld_q    <= 1'b0;
			step_count_q <= css_pkg::STEP_COUNT_RST;
			pulse_q      <= css_pkg::PULSE_TICKS_RST;
			ov_q         <= 1'b0;
		end else begin
			fwd_vld_q <= fwd_vld_n;
			if (go) begin
				st_q    <= st_n;
				phase_q <= phase_n;
				idx_q   <= idx_n;
				beat_q  <= beat_n;
				el_q    <= el_n;
				plays_q <= plays_n;
				lowp_q  <= lowp_n;
				highp_q <= highp_n;
				tokl_q  <= tokl_n;
				cycl_q  <= cycl_n;
				tick_q  <= tick_n;
			end
			if (go && fin) begin
				ov_q <= 1'b1;
			end else if (results.ready) begin
				ov_q <= 1'b0;
			end
			if (wr_en) begin
				unique case (wr_index)
					css_pkg::REG_STEP_COUNT:  step_count_q <= wr_data[css_pkg::COUNT_W-1:0];
					css_pkg::REG_PULSE_TICKS: pulse_q      <= wr_data;
					default:                  pulse_q      <= pulse_q;
				endcase
			end
		end
	end

	// hold the payload of a result until it is taken; also register rnd_q and the forwarded load entry
	always_ff @(posedge clk) begin
		rnd_q <= go ? rnd_n : rnd_q;
		if (fwd_vld_n) begin
			fwd_q <= load_e;
		end
		if (go && fin) begin
			gate_q <= gate;
			tok_q  <= tok;
			cyc_q  <= cyc;
			cur_q  <= idx_n;
			ramp_q <= phase_n;
		end
	end

	assign results.valid        = ov_q;
	assign results.clock_gate   = gate_q;
	assign results.token_eoc    = tok_q;
	assign results.cycle_eoc    = cyc_q;
	assign results.current_step = cur_q;
	assign results.ramp         = ramp_q;

endmodule

### rtl/css_ram.sv
// Generic single-write, single-read RAM with registered read data (read-old).
// No dependencies.
module css_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
